// ===== rtl/btgl_pkg.sv =====
package btgl_pkg;

    localparam int COORD_W = 11;
    localparam int CODE_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    localparam int FIRST_GLYPH_CODE = 33;
    localparam int GLYPH_COUNT      = 118;
    localparam int TAB_STOP         = 32;
    localparam int GLYPH_IDX_W      = $clog2(GLYPH_COUNT);

    // special character codes
    localparam logic [CODE_W-1:0] CODE_TAB     = 8'h09;
    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 8'h20;
    localparam logic [CODE_W-1:0] CODE_INVALID = 8'h7F;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FONT_BASE_U   = 3'd0,
        CFG_FONT_BASE_V   = 3'd1,
        CFG_FONT_PALETTE  = 3'd2,
        CFG_SPACE_ADVANCE = 3'd3,
        CFG_LINE_ADVANCE  = 3'd4
    } cfg_index_t;

    localparam logic [3:0] SPACE_ADVANCE_RESET = 4'd4;
    localparam logic [4:0] LINE_ADVANCE_RESET  = 5'd10;

    typedef struct packed {
        logic [6:0] gx;
        logic [6:0] gy;
        logic [3:0] gw;
        logic [3:0] gh;
    } glyph_t;

    function automatic glyph_t gl(input int x, input int y, input int w, input int h);
        glyph_t g;
        g.gx = 7'(x);
        g.gy = 7'(y);
        g.gw = 4'(w);
        g.gh = 4'(h);
        return g;
    endfunction

    localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
        gl(6,0,2,9), gl(12,0,4,9), gl(18,0,6,9), gl(24,0,6,9), gl(30,0,6,9),
        gl(36,0,6,9), gl(42,0,2,9), gl(48,0,3,9), gl(54,0,3,9), gl(60,0,4,9),
        gl(66,0,6,9), gl(72,0,3,9), gl(78,0,6,9), gl(84,0,2,9), gl(90,0,6,9),
        gl(0,9,6,9), gl(6,9,6,9), gl(12,9,6,9), gl(18,9,6,9), gl(24,9,6,9),
        gl(30,9,6,9), gl(36,9,6,9), gl(42,9,6,9), gl(48,9,6,9), gl(54,9,6,9),
        gl(60,9,2,9), gl(66,9,3,9), gl(72,9,6,9), gl(78,9,6,9), gl(84,9,6,9),
        gl(90,9,6,9),
        gl(0,18,6,9), gl(6,18,6,9), gl(12,18,6,9), gl(18,18,6,9), gl(24,18,6,9),
        gl(30,18,6,9), gl(36,18,6,9), gl(42,18,6,9), gl(48,18,6,9), gl(54,18,4,9),
        gl(60,18,5,9), gl(66,18,6,9), gl(72,18,6,9), gl(78,18,6,9), gl(84,18,6,9),
        gl(90,18,6,9),
        gl(0,27,6,9), gl(6,27,6,9), gl(12,27,6,9), gl(18,27,6,9), gl(24,27,6,9),
        gl(30,27,6,9), gl(36,27,6,9), gl(42,27,6,9), gl(48,27,6,9), gl(54,27,6,9),
        gl(60,27,6,9), gl(66,27,3,9), gl(72,27,6,9), gl(78,27,3,9), gl(84,27,4,9),
        gl(90,27,6,9),
        gl(0,36,3,9), gl(6,36,6,9), gl(12,36,6,9), gl(18,36,6,9), gl(24,36,6,9),
        gl(30,36,6,9), gl(36,36,5,9), gl(42,36,6,9), gl(48,36,5,9), gl(54,36,2,9),
        gl(60,36,4,9), gl(66,36,5,9), gl(72,36,2,9), gl(78,36,6,9), gl(84,36,5,9),
        gl(90,36,6,9),
        gl(0,45,6,9), gl(6,45,6,9), gl(12,45,6,9), gl(18,45,6,9), gl(24,45,5,9),
        gl(30,45,5,9), gl(36,45,6,9), gl(42,45,6,9), gl(48,45,6,9), gl(54,45,6,9),
        gl(60,45,5,9), gl(66,45,4,9), gl(72,45,2,9), gl(78,45,4,9), gl(84,45,6,9),
        gl(90,45,6,9),
        gl(0,54,6,9), gl(6,54,6,9), gl(12,54,4,9), gl(18,54,4,9), gl(24,54,6,9),
        gl(30,54,6,9), gl(36,54,6,9), gl(42,54,6,9),
        gl(0,63,7,9), gl(12,63,7,9), gl(24,63,9,9), gl(36,63,8,10), gl(48,63,11,10),
        gl(60,63,12,10), gl(72,63,14,9),
        gl(0,73,10,10), gl(12,73,10,10), gl(24,73,10,10), gl(36,73,10,9),
        gl(48,73,10,9), gl(60,73,10,10), gl(72,73,10,10), gl(85,73,8,8)
    };

    // rom slot of the invalid glyph, entry 0 if it falls outside the rom
    localparam int INVALID_SLOT_INT =
        (int'(CODE_INVALID) >= FIRST_GLYPH_CODE &&
         int'(CODE_INVALID) - FIRST_GLYPH_CODE < GLYPH_COUNT) ?
        int'(CODE_INVALID) - FIRST_GLYPH_CODE : 0;
    localparam logic [GLYPH_IDX_W-1:0] INVALID_SLOT = GLYPH_IDX_W'(INVALID_SLOT_INT);

    function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code);
        logic [CODE_W:0]          rel;
        logic [GLYPH_IDX_W-1:0]   slot;
        rel  = {1'b0, code} - (CODE_W+1)'(FIRST_GLYPH_CODE);
        slot = INVALID_SLOT;
        if (int'(code) >= FIRST_GLYPH_CODE && int'(code) < FIRST_GLYPH_CODE + GLYPH_COUNT)
        begin
            slot = rel[GLYPH_IDX_W-1:0];
        end
        return GLYPH_ROM[slot];
    endfunction

endpackage

// ===== rtl/bitmap_text_glyph_layout_unit.sv =====
// a request passes from the input register to the result register behind out_valid;
// one request per cycle unless the result register is full and stalled; the cursor
// update is combinational from the input register: the loop holds no request back
// in_stall rises only while the input register holds a request and the result
// register is full and stalled; reset clears cursor, line origin, valid flags
// and loads the font registers with their defaults (space 4, line 10, rest 0)
module bitmap_text_glyph_layout_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write_en,
    input  logic [btgl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btgl_pkg::CFG_W-1:0]        cfg_wdata,
    // character request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [btgl_pkg::CODE_W-1:0]       char_code,
    input  logic                              string_start,
    input  logic [btgl_pkg::COORD_W-1:0]      origin_x,
    input  logic [btgl_pkg::COORD_W-1:0]      origin_y,
    // sprite request channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [btgl_pkg::COORD_W-1:0]      draw_x,
    output logic [btgl_pkg::COORD_W-1:0]      draw_y,
    output logic [7:0]                        tex_u,
    output logic [7:0]                        tex_v,
    output logic [15:0]                       palette,
    output logic [3:0]                        glyph_width,
    output logic [3:0]                        glyph_height
);

    localparam int CW = btgl_pkg::COORD_W;

    // font registers
    logic [7:0]    font_base_u_reg;
    logic [7:0]    font_base_v_reg;
    logic [15:0]   font_palette_reg;
    logic [3:0]    space_advance_reg;
    logic [4:0]    line_advance_reg;

    // input register
    logic                          in_valid_reg;
    logic [btgl_pkg::CODE_W-1:0]   code_reg;
    logic                          start_reg;
    logic [CW-1:0]                 origin_x_reg;
    logic [CW-1:0]                 origin_y_reg;

    // text cursor
    logic [CW-1:0]  cursor_x_reg, cursor_x_next;
    logic [CW-1:0]  cursor_y_reg, cursor_y_next;
    logic [CW-1:0]  line_origin_reg, line_origin_next;

    // result register
    logic           out_valid_reg, out_valid_next;
    logic [CW-1:0]  draw_x_reg;
    logic [CW-1:0]  draw_y_reg;
    logic [7:0]     tex_u_reg;
    logic [7:0]     tex_v_reg;
    logic [15:0]    palette_reg;
    logic [3:0]     glyph_width_reg;
    logic [3:0]     glyph_height_reg;

    logic               advance;
    logic               accept;
    logic               is_tab;
    logic               is_newline;
    logic               is_space;
    logic               is_glyph;
    logic [CW-1:0]      cur_x;
    logic [CW-1:0]      cur_y;
    logic [CW-1:0]      cur_origin;
    logic [CW:0]        tab_sum;
    logic [CW:0]        tab_round;
    logic [CW:0]        x_plus;
    logic [CW:0]        y_plus;
    logic [3:0]         x_step;
    btgl_pkg::glyph_t   glyph;

    // input register moves on unless the result register is full and held
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // a string start overrides the cursor before the code is handled
    assign cur_x      = start_reg ? origin_x_reg : cursor_x_reg;
    assign cur_y      = start_reg ? origin_y_reg : cursor_y_reg;
    assign cur_origin = start_reg ? origin_x_reg : line_origin_reg;

    assign is_tab     = (code_reg == btgl_pkg::CODE_TAB);
    assign is_newline = (code_reg == btgl_pkg::CODE_NEWLINE);
    assign is_space   = (code_reg == btgl_pkg::CODE_SPACE);
    assign is_glyph   = !(is_tab || is_newline || is_space);

    assign glyph = btgl_pkg::glyph_lookup(code_reg);

    // tab: round up to the next tab stop, one bit of headroom then saturate
    assign tab_sum   = {1'b0, cur_x} + (CW+1)'(btgl_pkg::TAB_STOP - 1);
    assign tab_round = tab_sum - (tab_sum % (CW+1)'(btgl_pkg::TAB_STOP));

    // space and glyph share one horizontal adder
    assign x_step = is_space ? space_advance_reg : glyph.gw;
    assign x_plus = {1'b0, cur_x} + (CW+1)'(x_step);
    assign y_plus = {1'b0, cur_y} + (CW+1)'(line_advance_reg);

    always_comb
    begin
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        line_origin_next = line_origin_reg;
        if (advance)
        begin
            cursor_y_next    = cur_y;
            line_origin_next = cur_origin;
            if (is_tab)
            begin
                cursor_x_next = tab_round[CW] ? btgl_pkg::COORD_MAX : tab_round[CW-1:0];
            end
            else if (is_newline)
            begin
                cursor_x_next = cur_origin;
                cursor_y_next = y_plus[CW] ? btgl_pkg::COORD_MAX : y_plus[CW-1:0];
            end
            else
            begin
                // space or drawn glyph, both saturate at the screen edge
                cursor_x_next = x_plus[CW] ? btgl_pkg::COORD_MAX : x_plus[CW-1:0];
            end
        end
    end

    always_comb
    begin
        if (advance && is_glyph)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_base_u_reg   <= '0;
            font_base_v_reg   <= '0;
            font_palette_reg  <= '0;
            space_advance_reg <= btgl_pkg::SPACE_ADVANCE_RESET;
            line_advance_reg  <= btgl_pkg::LINE_ADVANCE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                btgl_pkg::CFG_FONT_BASE_U:   font_base_u_reg   <= cfg_wdata[7:0];
                btgl_pkg::CFG_FONT_BASE_V:   font_base_v_reg   <= cfg_wdata[7:0];
                btgl_pkg::CFG_FONT_PALETTE:  font_palette_reg  <= cfg_wdata;
                btgl_pkg::CFG_SPACE_ADVANCE: space_advance_reg <= cfg_wdata[3:0];
                btgl_pkg::CFG_LINE_ADVANCE:  line_advance_reg  <= cfg_wdata[4:0];
                default:                     ;
            endcase
        end
    end

    // control state: valid flags and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            line_origin_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg   <= out_valid_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            line_origin_reg <= line_origin_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg     <= char_code;
            start_reg    <= string_start;
            origin_x_reg <= origin_x;
            origin_y_reg <= origin_y;
        end
        if (advance && is_glyph)
        begin
            draw_x_reg       <= cur_x;
            draw_y_reg       <= cur_y;
            tex_u_reg        <= font_base_u_reg + 8'(glyph.gx);
            tex_v_reg        <= font_base_v_reg + 8'(glyph.gy);
            palette_reg      <= font_palette_reg;
            glyph_width_reg  <= glyph.gw;
            glyph_height_reg <= glyph.gh;
        end
    end

    assign out_valid    = out_valid_reg;
    assign draw_x       = draw_x_reg;
    assign draw_y       = draw_y_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign palette      = palette_reg;
    assign glyph_width  = glyph_width_reg;
    assign glyph_height = glyph_height_reg;

    // stall only when a held request meets a full, stalled result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // cursor only moves when a request leaves the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(cursor_x_reg) && $stable(cursor_y_reg)))
        else $error("cursor moved without a request");

    // after a tab the cursor sits on a tab stop or at the edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_tab) |=>
        ((cursor_x_reg % CW'(btgl_pkg::TAB_STOP)) == '0 ||
         cursor_x_reg == btgl_pkg::COORD_MAX))
        else $error("tab left cursor off a tab stop");

    // a new sprite appears only from a drawn glyph
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && is_glyph))
        else $error("sprite without a glyph request");

endmodule

// ===== bench/bitmap_text_glyph_layout_unit_tb.sv =====
module bitmap_text_glyph_layout_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // shared constants taken from the package
    localparam int COORD_W          = btgl_pkg::COORD_W;
    localparam int CODE_W           = btgl_pkg::CODE_W;
    localparam int CFG_W            = btgl_pkg::CFG_W;
    localparam int CFG_IDX_W        = btgl_pkg::CFG_IDX_W;
    localparam int FIRST_GLYPH_CODE = btgl_pkg::FIRST_GLYPH_CODE;
    localparam int GLYPH_COUNT      = btgl_pkg::GLYPH_COUNT;
    localparam int TAB_STOP         = btgl_pkg::TAB_STOP;
    localparam logic [COORD_W-1:0] COORD_MAX    = btgl_pkg::COORD_MAX;
    localparam logic [CODE_W-1:0]  CODE_TAB     = btgl_pkg::CODE_TAB;
    localparam logic [CODE_W-1:0]  CODE_NEWLINE = btgl_pkg::CODE_NEWLINE;
    localparam logic [CODE_W-1:0]  CODE_SPACE   = btgl_pkg::CODE_SPACE;
    localparam logic [CODE_W-1:0]  CODE_INVALID = btgl_pkg::CODE_INVALID;
    localparam btgl_pkg::cfg_index_t CFG_FONT_BASE_U   = btgl_pkg::CFG_FONT_BASE_U;
    localparam btgl_pkg::cfg_index_t CFG_FONT_BASE_V   = btgl_pkg::CFG_FONT_BASE_V;
    localparam btgl_pkg::cfg_index_t CFG_FONT_PALETTE  = btgl_pkg::CFG_FONT_PALETTE;
    localparam btgl_pkg::cfg_index_t CFG_SPACE_ADVANCE = btgl_pkg::CFG_SPACE_ADVANCE;
    localparam btgl_pkg::cfg_index_t CFG_LINE_ADVANCE  = btgl_pkg::CFG_LINE_ADVANCE;
    localparam logic [3:0] SPACE_ADVANCE_RESET = btgl_pkg::SPACE_ADVANCE_RESET;
    localparam logic [4:0] LINE_ADVANCE_RESET  = btgl_pkg::LINE_ADVANCE_RESET;

    // cycles without any accepted request before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // length of the one long receiver hold-off
    localparam int RX_HOLD_CYCLES = 200;
    // cycles to let a request that draws nothing clear the pipeline
    localparam int DRAIN_CYCLES = 4;
    // first register index that decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

    // font sheet: u, v, width, height per glyph slot, codes 33 upward
    localparam int FONT_SHEET [GLYPH_COUNT*4] = '{
        6,0,2,9,   12,0,4,9,  18,0,6,9,  24,0,6,9,  30,0,6,9,  36,0,6,9,
        42,0,2,9,  48,0,3,9,  54,0,3,9,  60,0,4,9,  66,0,6,9,  72,0,3,9,
        78,0,6,9,  84,0,2,9,  90,0,6,9,
        0,9,6,9,   6,9,6,9,   12,9,6,9,  18,9,6,9,  24,9,6,9,  30,9,6,9,
        36,9,6,9,  42,9,6,9,  48,9,6,9,  54,9,6,9,  60,9,2,9,  66,9,3,9,
        72,9,6,9,  78,9,6,9,  84,9,6,9,  90,9,6,9,
        0,18,6,9,  6,18,6,9,  12,18,6,9, 18,18,6,9, 24,18,6,9, 30,18,6,9,
        36,18,6,9, 42,18,6,9, 48,18,6,9, 54,18,4,9, 60,18,5,9, 66,18,6,9,
        72,18,6,9, 78,18,6,9, 84,18,6,9, 90,18,6,9,
        0,27,6,9,  6,27,6,9,  12,27,6,9, 18,27,6,9, 24,27,6,9, 30,27,6,9,
        36,27,6,9, 42,27,6,9, 48,27,6,9, 54,27,6,9, 60,27,6,9, 66,27,3,9,
        72,27,6,9, 78,27,3,9, 84,27,4,9, 90,27,6,9,
        0,36,3,9,  6,36,6,9,  12,36,6,9, 18,36,6,9, 24,36,6,9, 30,36,6,9,
        36,36,5,9, 42,36,6,9, 48,36,5,9, 54,36,2,9, 60,36,4,9, 66,36,5,9,
        72,36,2,9, 78,36,6,9, 84,36,5,9, 90,36,6,9,
        0,45,6,9,  6,45,6,9,  12,45,6,9, 18,45,6,9, 24,45,5,9, 30,45,5,9,
        36,45,6,9, 42,45,6,9, 48,45,6,9, 54,45,6,9, 60,45,5,9, 66,45,4,9,
        72,45,2,9, 78,45,4,9, 84,45,6,9, 90,45,6,9,
        0,54,6,9,  6,54,6,9,  12,54,4,9, 18,54,4,9, 24,54,6,9, 30,54,6,9,
        36,54,6,9, 42,54,6,9,
        0,63,7,9,  12,63,7,9, 24,63,9,9, 36,63,8,10, 48,63,11,10,
        60,63,12,10, 72,63,14,9,
        0,73,10,10, 12,73,10,10, 24,73,10,10, 36,73,10,9, 48,73,10,9,
        60,73,10,10, 72,73,10,10, 85,73,8,8
    };

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         u;
        logic [7:0]         v;
        logic [15:0]        pal;
        logic [3:0]         w;
        logic [3:0]         h;
    } sprite_t;

    // one line of the directed stimulus, with a typed-in sprite where obvious
    typedef struct {
        logic [CODE_W-1:0]  code;
        logic               start;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        bit                 typed;
        sprite_t            want;
    } text_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [CODE_W-1:0]     char_code;
    logic                  string_start;
    logic [COORD_W-1:0]    origin_x;
    logic [COORD_W-1:0]    origin_y;
    logic                  out_valid;
    logic                  out_stall;
    logic [COORD_W-1:0]    draw_x;
    logic [COORD_W-1:0]    draw_y;
    logic [7:0]            tex_u;
    logic [7:0]            tex_v;
    logic [15:0]           palette;
    logic [3:0]            glyph_width;
    logic [3:0]            glyph_height;

    // layout state mirrored from the block
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    logic [COORD_W-1:0] margin_x;
    logic [7:0]         sheet_u;
    logic [7:0]         sheet_v;
    logic [15:0]        pal_word;
    logic [3:0]         space_px;
    logic [4:0]         line_px;

    sprite_t   pending_sprites [$];
    text_row_t text_rows [$];
    int        fault_count;
    int        idle_cycles;

    // idling controls shared between the sender and the receiver
    bit tx_idling;
    bit tx_calm;
    bit rx_idling;
    bit hold_req;

    bitmap_text_glyph_layout_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .string_start (string_start),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .draw_x       (draw_x),
        .draw_y       (draw_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .palette      (palette),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // clamp a cursor sum to the screen edge
    function automatic logic [COORD_W-1:0] clamp_coord(input int v);
        return (v > int'(COORD_MAX)) ? COORD_MAX : COORD_W'(v);
    endfunction

    // advance the mirrored cursor for one character, fill spr if it draws
    function automatic bit layout_char(input logic [CODE_W-1:0] code, input logic start,
                                       input logic [COORD_W-1:0] ox,
                                       input logic [COORD_W-1:0] oy,
                                       output sprite_t spr);
        int slot;
        int t;
        spr = '0;
        if (start)
        begin
            pen_x    = ox;
            margin_x = ox;
            pen_y    = oy;
        end
        if (code == CODE_TAB)
        begin
            // round up to the next tab stop, a stop already reached stays
            t = int'(pen_x) + TAB_STOP - 1;
            t = t - t % TAB_STOP;
            pen_x = clamp_coord(t);
            return 1'b0;
        end
        if (code == CODE_NEWLINE)
        begin
            pen_x = margin_x;
            pen_y = clamp_coord(int'(pen_y) + int'(line_px));
            return 1'b0;
        end
        if (code == CODE_SPACE)
        begin
            pen_x = clamp_coord(int'(pen_x) + int'(space_px));
            return 1'b0;
        end
        // anything outside the sheet, control codes too, draws the invalid glyph
        if (code >= FIRST_GLYPH_CODE && code < FIRST_GLYPH_CODE + GLYPH_COUNT)
            slot = int'(code) - FIRST_GLYPH_CODE;
        else
            slot = int'(CODE_INVALID) - FIRST_GLYPH_CODE;
        spr.x   = pen_x;
        spr.y   = pen_y;
        spr.u   = 8'(int'(sheet_u) + FONT_SHEET[slot*4]);
        spr.v   = 8'(int'(sheet_v) + FONT_SHEET[slot*4+1]);
        spr.pal = pal_word;
        spr.w   = 4'(FONT_SHEET[slot*4+2]);
        spr.h   = 4'(FONT_SHEET[slot*4+3]);
        pen_x   = clamp_coord(int'(pen_x) + FONT_SHEET[slot*4+2]);
        return 1'b1;
    endfunction

    // directed line whose sprite, if any, comes from the predictor
    function automatic void add_row(input logic [CODE_W-1:0] code, input logic start,
                                    input int ox, input int oy);
        text_row_t r;
        r.code  = code;
        r.start = start;
        r.ox    = COORD_W'(ox);
        r.oy    = COORD_W'(oy);
        r.typed = 1'b0;
        r.want  = '0;
        text_rows.push_back(r);
    endfunction

    // directed line with its sprite typed in, palette at its reset value
    function automatic void add_drawn(input logic [CODE_W-1:0] code, input logic start,
                                      input int ox, input int oy, input int x, input int y,
                                      input int u, input int v, input int w, input int h);
        text_row_t r;
        r.code  = code;
        r.start = start;
        r.ox    = COORD_W'(ox);
        r.oy    = COORD_W'(oy);
        r.typed = 1'b1;
        r.want  = {COORD_W'(x), COORD_W'(y), 8'(u), 8'(v), 16'h0000, 4'(w), 4'(h)};
        text_rows.push_back(r);
    endfunction

    // offer one character request and hold it until it is taken
    task automatic push_char(input logic [CODE_W-1:0] code, input logic start,
                             input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                             input bit typed, input sprite_t want);
        int      gap;
        sprite_t spr;
        if (tx_idling && !tx_calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_code    <= code;
        string_start <= start;
        origin_x     <= ox;
        origin_y     <= oy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // accepted at this edge: the sprite it draws joins the queue now
        if (layout_char(code, start, ox, oy, spr))
            pending_sprites.push_back(typed ? want : spr);
    endtask

    // one register write; the caller lowers the enable after a series
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= data;
        @(posedge clk);
        case (idx)
            CFG_FONT_BASE_U:   sheet_u  = data[7:0];
            CFG_FONT_BASE_V:   sheet_v  = data[7:0];
            CFG_FONT_PALETTE:  pal_word = data[15:0];
            CFG_SPACE_ADVANCE: space_px = data[3:0];
            CFG_LINE_ADVANCE:  line_px  = data[4:0];
            default: ;
        endcase
    endtask

    // load all font registers, junk in the unused upper bits, then poke spare indexes
    task automatic set_font(input logic [7:0] u, input logic [7:0] v, input logic [15:0] pal,
                            input logic [3:0] sp, input logic [4:0] ln);
        write_reg(CFG_FONT_BASE_U,   {8'($urandom), u});
        write_reg(CFG_FONT_BASE_V,   {8'($urandom), v});
        write_reg(CFG_FONT_PALETTE,  pal);
        write_reg(CFG_SPACE_ADVANCE, {12'($urandom), sp});
        write_reg(CFG_LINE_ADVANCE,  {11'($urandom), ln});
        for (int i = CFG_SPARE_FIRST; i < 2**CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), 16'($urandom));
        cfg_write_en <= 1'b0;
    endtask

    // stop sending and wait for every sprite plus the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sprites.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly glyphs, with the moving codes and codes without a glyph mixed in
    function automatic logic [CODE_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62)
            return CODE_W'($urandom_range(FIRST_GLYPH_CODE, FIRST_GLYPH_CODE + GLYPH_COUNT - 1));
        if (r < 72)
            return CODE_SPACE;
        if (r < 78)
            return CODE_TAB;
        if (r < 84)
            return CODE_NEWLINE;
        if (r < 92)
            return CODE_W'($urandom_range(FIRST_GLYPH_CODE + GLYPH_COUNT, 255));
        return CODE_W'($urandom_range(0, FIRST_GLYPH_CODE - 1));
    endfunction

    // origins near the corners make saturation common
    function automatic logic [COORD_W-1:0] pick_origin();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return COORD_W'($urandom_range(0, 63));
        if (r == 1)
            return COORD_W'($urandom_range(1900, 2047));
        return COORD_W'($urandom);
    endfunction

    // random strings: a start request then the text, with some loose noise requests
    task automatic run_strings(input int count, input bit with_hold);
        int  sent;
        int  len;
        bit  held;
        sent = 0;
        held = 1'b0;
        while (sent < count)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if (with_hold && !held && sent >= 40)
            begin
                // receiver stops for a long while, the sender keeps pushing
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                push_char(CODE_W'($urandom), 1'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), 1'b0, '0);
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 30);
                push_char(pick_char(), 1'b1, pick_origin(), pick_origin(), 1'b0, '0);
                repeat (len)
                    push_char(pick_char(), 1'b0, COORD_W'($urandom), COORD_W'($urandom),
                              1'b0, '0);
                sent += len + 1;
            end
        end
    endtask

    // receiver: random stall bursts, quiet stretches, and the long hold-off
    initial
    begin : receiver
        int burst_left;
        int quiet_left;
        int hold_left;
        bit hold_done;
        burst_left = 0;
        quiet_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = RX_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (quiet_left > 0)
                    quiet_left--;
                else if (rx_idling)
                begin
                    if ($urandom_range(0, 19) == 0)
                        quiet_left = $urandom_range(20, 60);
                    else if ($urandom_range(0, 4) == 0)
                        burst_left = $urandom_range(1, 14);
                end
            end
        end
    end

    // every accepted sprite request is checked against the oldest queued one
    always @(posedge clk)
    begin : sprite_check
        sprite_t got;
        sprite_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {draw_x, draw_y, tex_u, tex_v, palette, glyph_width, glyph_height};
            if (pending_sprites.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected sprite x=%0d y=%0d u=%0d v=%0d", got.x, got.y,
                             got.u, got.v);
            end
            else
            begin
                want = pending_sprites.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.u !== want.u ||
                    got.v !== want.v || got.pal !== want.pal || got.w !== want.w ||
                    got.h !== want.h)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("sprite mismatch want x=%0d y=%0d u=%0d v=%0d pal=%h w=%0d h=%0d",
                                 want.x, want.y, want.u, want.v, want.pal, want.w, want.h);
                        $display("                 got x=%0d y=%0d u=%0d v=%0d pal=%h w=%0d h=%0d",
                                 got.x, got.y, got.u, got.v, got.pal, got.w, got.h);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_FONT_BASE_U;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        char_code    = '0;
        string_start = 1'b0;
        origin_x     = '0;
        origin_y     = '0;
        tx_idling    = 1'b1;
        tx_calm      = 1'b0;
        rx_idling    = 1'b1;
        hold_req     = 1'b0;

        // mirror of the reset state
        pen_x    = '0;
        pen_y    = '0;
        margin_x = '0;
        sheet_u  = '0;
        sheet_v  = '0;
        pal_word = '0;
        space_px = SPACE_ADVANCE_RESET;
        line_px  = LINE_ADVANCE_RESET;

        // directed text at the reset font settings
        add_drawn(8'h21, 1'b1, 0, 0, 0, 0, 6, 0, 2, 9);
        // code zero and codes past the sheet draw the invalid glyph; 8'h96 is the last sheet glyph
        add_drawn(8'h00, 1'b0, 2047, 2047, 2, 0, 90, 45, 6, 9);
        add_drawn(8'h96, 1'b0, 0, 0, 8, 0, 85, 73, 8, 8);
        add_drawn(8'h97, 1'b0, 0, 0, 16, 0, 90, 45, 6, 9);
        add_drawn(8'hFF, 1'b0, 0, 0, 22, 0, 90, 45, 6, 9);
        // tab to the next stop, then a tab already on a stop
        add_row(CODE_TAB, 1'b0, 0, 0);
        add_row(CODE_TAB, 1'b0, 0, 0);
        add_row(CODE_SPACE, 1'b0, 0, 0);
        add_row(8'h41, 1'b0, 0, 0);
        add_row(CODE_NEWLINE, 1'b0, 0, 0);
        // everything pinned at the far corner
        add_row(CODE_SPACE, 1'b1, 2047, 2047);
        add_drawn(CODE_INVALID, 1'b1, 2047, 2047, 2047, 2047, 90, 45, 6, 9);
        add_row(CODE_TAB, 1'b0, 0, 0);
        add_row(CODE_NEWLINE, 1'b0, 0, 0);
        add_drawn(8'h01, 1'b0, 0, 0, 2047, 2047, 90, 45, 6, 9);
        add_row(CODE_TAB, 1'b1, 2040, 5);
        add_row(CODE_NEWLINE, 1'b1, 100, 2040);
        add_row(8'h6D, 1'b0, 0, 0);
        add_row(8'h75, 1'b1, 'h555, 'h2AA);
        add_row(8'h8A, 1'b1, 'h2AA, 'h555);
        add_row(8'h0B, 1'b0, 0, 0);
        add_row(8'h1F, 1'b0, 0, 0);
        add_row(8'h08, 1'b0, 0, 0);
        add_row(8'h20, 1'b0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (text_rows[i])
            push_char(text_rows[i].code, text_rows[i].start, text_rows[i].ox,
                      text_rows[i].oy, text_rows[i].typed, text_rows[i].want);

        // every register at its top value, with the long receiver hold-off
        settle();
        set_font(8'hFF, 8'hFF, 16'hFFFF, 4'hF, 5'h1F);
        run_strings(200, 1'b1);

        // every register at zero: spaces and newlines stop moving the cursor
        settle();
        set_font(8'h00, 8'h00, 16'h0000, 4'h0, 5'h00);
        run_strings(200, 1'b0);

        settle();
        set_font(8'($urandom), 8'($urandom), 16'($urandom), 4'($urandom), 5'($urandom));
        run_strings(200, 1'b0);

        settle();
        set_font(8'($urandom), 8'($urandom), 16'($urandom), 4'($urandom), 5'($urandom));
        run_strings(200, 1'b0);

        // last stretch at full rate on both sides
        settle();
        set_font(8'($urandom), 8'($urandom), 16'($urandom), 4'($urandom), 5'($urandom));
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_strings(150, 1'b0);

        settle();
        if (fault_count == 0 && pending_sprites.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
